@@ src/bmp_pkg.sv @@
// bmp_pkg: shared types, codes and helpers for the bus mouse interface
// no dependencies
`default_nettype none

package bmp_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE_C = 3'd0,
        KIND_CONTROL = 3'd1,
        KIND_TIMING  = 3'd2,
        KIND_READ_A  = 3'd3,
        KIND_READ_B  = 3'd4,
        KIND_READ_C  = 3'd5,
        KIND_MOTION  = 3'd6,
        KIND_TICK    = 3'd7
    } kind_t;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 16;
    localparam int UNITS_W   = 22;
    localparam int PADDR_W   = 5;

    localparam logic [31:0] SPREAD_MIN     = 32'd2000;
    localparam logic [15:0] TICKS_PER_UNIT = 16'd1000;
    localparam logic [7:0]  RAPID_MASK     = 8'ha0;
    localparam logic [7:0]  PORT_A_FIXED   = 8'h50;
    localparam logic [7:0]  PORT_B_VALUE   = 8'h40;
    localparam logic [7:0]  PORT_C_RESET   = 8'h10;
    localparam logic [7:0]  MODE_RESET     = 8'h93;
    localparam logic [7:0]  PORT_C_LOW5    = 8'h1f;
    localparam logic [7:0]  HIGH_NIBBLE    = 8'hf0;
    localparam logic [7:0]  DIP_MARK       = 8'h08;

    // elapsed / 1000 as (elapsed >> 3) * ceil(2^35 / 125) >> 35, exact below 2^31
    localparam logic [28:0] RECIP_125   = 29'd274877907;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [15:0] MOVE_PERIOD_RESET = 16'd354;
    localparam logic [23:0] IRQ_PERIOD_RESET  = 24'd166400;

    typedef enum logic [2:0] {
        REG_MOVE_PERIOD = 3'd0,
        REG_IRQ_PERIOD  = 3'd1,
        REG_RAPID       = 3'd2,
        REG_DIP_A       = 3'd3,
        REG_DIP_C       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] move_period;
        logic [23:0] irq_period;
        logic        rapid_enable;
        logic [7:0]  dip_bank_a;
        logic [7:0]  dip_bank_c;
    } cfg_t;

    typedef struct packed {
        logic load;       // capture item, evaluate interrupt
        logic time_div;   // register reciprocal product of elapsed, toggle rapid bits
        logic take_units; // store units, advance last_time
        logic mul;        // register |sample| * units
        logic move_div;   // start product / move_period
        logic apply;      // add clipped step into counter
        logic sel_y;
        logic finish;     // commit item, load result register
    } cmd_t;

    typedef struct packed {
        logic need_spread;
        logic div_done;
    } status_t;

    function automatic logic [15:0] sat16(input logic [17:0] v);
        logic [15:0] r;
        if (!v[17] && v[16:15] != 2'b00)
            r = 16'h7fff;
        else if (v[17] && v[16:15] != 2'b11)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp8(input logic [15:0] v);
        logic [7:0] r;
        if (!v[15] && v[14:7] != 8'h00)
            r = 8'h7f;
        else if (v[15] && v[14:7] != 8'hff)
            r = 8'h80;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/bmp_req_if.sv @@
// bmp_req_if / bmp_rsp_if: valid/ready channels for requests and results
// no dependencies
`default_nettype none

interface bmp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  data;
    logic [11:0] move_x;
    logic [11:0] move_y;
    logic [7:0]  buttons;
    logic [31:0] now;

    modport source (output valid, req_type, data, move_x, move_y, buttons, now,
                    input ready);
    modport sink   (input valid, req_type, data, move_x, move_y, buttons, now,
                    output ready);
endinterface

interface bmp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;

    modport source (output valid, read_data, irq, input ready);
    modport sink   (input valid, read_data, irq, output ready);
endinterface

`default_nettype wire

@@ src/bmp_div.sv @@
// bmp_div: restoring divider, one quotient bit per cycle
// depends on bmp_pkg
`default_nettype none

module bmp_div
    import bmp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_DEN_W-1:0] rem_reg, den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DEN_W:0]   trial, diff;
    logic                 fits;

    assign trial = {rem_reg, quot_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_NUM_W-2:0], fits};
            rem_reg  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ src/bmp_ctrl.sv @@
// bmp_ctrl: sequencer for one item, handshakes on both channels
// depends on bmp_pkg
`default_nettype none

module bmp_ctrl
    import bmp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    input  status_t   status,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_TDIV, S_MULX, S_SDX, S_WDX, S_APX,
        S_MULY, S_SDY, S_WDY, S_APY, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.need_spread)
                begin
                    cmd.time_div = 1'b1;
                    state_next   = S_TDIV;
                end
                else
                    state_next = S_FINISH;
            end
            S_TDIV:
            begin
                cmd.take_units = 1'b1;
                state_next     = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SDX;
            end
            S_SDX:
            begin
                cmd.move_div = 1'b1;
                state_next   = S_WDX;
            end
            S_WDX:
            begin
                if (status.div_done)
                    state_next = S_APX;
            end
            S_APX:
            begin
                cmd.apply  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul    = 1'b1;
                cmd.sel_y  = 1'b1;
                state_next = S_SDY;
            end
            S_SDY:
            begin
                cmd.move_div = 1'b1;
                state_next   = S_WDY;
            end
            S_WDY:
            begin
                if (status.div_done)
                    state_next = S_APY;
            end
            S_APY:
            begin
                cmd.apply  = 1'b1;
                cmd.sel_y  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/bmp_dp.sv @@
// bmp_dp: mouse state, motion spreading arithmetic, port logic, result register
// depends on bmp_pkg and bmp_div
`default_nettype none

module bmp_dp
    import bmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    output status_t          status,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  data,
    input  wire logic [11:0] move_x,
    input  wire logic [11:0] move_y,
    input  wire logic [7:0]  buttons,
    input  wire logic [31:0] now,
    output logic [7:0]       read_data,
    output logic             irq
);

    // item capture
    kind_t       kind_reg;
    logic [7:0]  data_reg, btn_reg;
    logic [11:0] mx_reg, my_reg;
    logic [31:0] now_reg;

    // block state
    logic [15:0] count_x_reg, count_y_reg, pend_x_reg, pend_y_reg;
    logic [11:0] sample_x_reg, sample_y_reg;
    logic [7:0]  latched_x_reg, latched_y_reg, button_reg, rapid_reg;
    logic [31:0] last_time_reg, irq_due_reg;
    logic [7:0]  port_c_reg, mode_reg;
    logic [1:0]  shift_reg;
    logic        armed_reg;

    // spreading
    logic [56:0]          units_prod_reg;
    logic [UNITS_W-1:0]   units_w;
    logic [UNITS_W-1:0]   units_reg;
    logic [DIV_NUM_W-1:0] prod_reg;
    logic                 smp_neg_reg, smp_zero_reg;

    logic [7:0] rd_reg;
    logic       irq_reg, irq_out_reg;

    logic [31:0] interval, elapsed, due_diff;
    logic        due_now;
    logic        write_en, latch_edge;
    logic [7:0]  wval, bitmask;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIV_DEN_W-1:0] div_den;

    logic [11:0] smp, mag;
    logic [15:0] pend, cnt;
    logic [16:0] neg_pend, step;
    logic [17:0] step_sum;

    logic [7:0]  rd_val, nib_src;
    logic [15:0] motion_x, motion_y;

    assign interval = 32'({cfg.irq_period, 3'b000} >> (2'd3 - shift_reg));
    assign elapsed  = now_reg - last_time_reg;
    assign due_diff = now - irq_due_reg;
    assign due_now  = !due_diff[31];

    // port C value produced by this item, if it writes one
    assign bitmask = 8'd1 << data_reg[3:1];
    always_comb
    begin
        write_en = 1'b0;
        wval     = port_c_reg;
        case (kind_reg)
            KIND_WRITE_C:
            begin
                write_en = 1'b1;
                wval     = data_reg;
            end
            KIND_CONTROL:
            begin
                if ((data_reg & HIGH_NIBBLE) == 8'h00)
                begin
                    write_en = 1'b1;
                    wval     = data_reg[0] ? (port_c_reg | bitmask) : (port_c_reg & ~bitmask);
                end
                else if (data_reg[7])
                begin
                    write_en = 1'b1;
                    wval     = 8'h00;
                end
            end
            default: ;
        endcase
    end

    assign latch_edge = write_en && wval[7] && !port_c_reg[7];
    assign status.need_spread = (kind_reg == KIND_READ_A || latch_edge)
                                && !elapsed[31] && elapsed >= SPREAD_MIN;
    assign status.div_done = div_done;

    // whole units of 1000 ticks in the elapsed time
    assign units_w = units_prod_reg[RECIP_SHIFT +: UNITS_W];

    assign div_start = cmd.move_div;
    assign div_num   = prod_reg;
    assign div_den   = cfg.move_period == 16'd0 ? 16'd1 : cfg.move_period;

    bmp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign smp = cmd.sel_y ? sample_y_reg : sample_x_reg;
    assign mag = smp[11] ? (~smp + 12'd1) : smp;
    assign pend = cmd.sel_y ? pend_y_reg : pend_x_reg;
    assign cnt  = cmd.sel_y ? count_y_reg : count_x_reg;
    assign neg_pend = 17'd0 - {pend[15], pend};

    // step clipped to what is still pending
    always_comb
    begin
        if (smp_zero_reg)
            step = '0;
        else if (!smp_neg_reg)
        begin
            if (pend[15] || div_q > {17'd0, pend})
                step = {pend[15], pend};
            else
                step = div_q[16:0];
        end
        else
        begin
            if ((!pend[15] && pend != 16'd0) || div_q > {16'd0, neg_pend})
                step = {pend[15], pend};
            else
                step = 17'd0 - div_q[16:0];
        end
    end
    assign step_sum = {{2{cnt[15]}}, cnt} + {step[16], step};

    assign motion_x = sat16({{2{count_x_reg[15]}}, count_x_reg} + {{2{pend_x_reg[15]}}, pend_x_reg});
    assign motion_y = sat16({{2{count_y_reg[15]}}, count_y_reg} + {{2{pend_y_reg[15]}}, pend_y_reg});

    // result byte
    always_comb
    begin
        nib_src = port_c_reg[7]
                ? (port_c_reg[6] ? latched_y_reg : latched_x_reg)
                : (port_c_reg[6] ? count_y_reg[7:0] : count_x_reg[7:0]);
        rd_val = 8'h00;
        case (kind_reg)
            KIND_READ_A:
            begin
                rd_val = button_reg | (cfg.rapid_enable ? rapid_reg : 8'h00);
                rd_val = (rd_val & HIGH_NIBBLE) | PORT_A_FIXED;
                rd_val = rd_val | {4'h0, port_c_reg[5] ? nib_src[7:4] : nib_src[3:0]};
            end
            KIND_READ_B: rd_val = PORT_B_VALUE;
            KIND_READ_C:
            begin
                rd_val = port_c_reg;
                if (mode_reg[3])
                    rd_val = rd_val & PORT_C_LOW5;
                if (mode_reg[0])
                    rd_val = (rd_val & HIGH_NIBBLE) | DIP_MARK
                           | {5'h0, cfg.dip_bank_c[7], ~cfg.dip_bank_a[5:4]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(req_type);
            data_reg <= data;
            mx_reg   <= move_x;
            my_reg   <= move_y;
            btn_reg  <= buttons;
            now_reg  <= now;
        end
        // elapsed is below 2^31 here; divide by 8 first, then by 125
        if (cmd.time_div)
            units_prod_reg <= {29'd0, elapsed[30:3]} * {28'd0, RECIP_125};
        if (cmd.take_units)
            units_reg <= units_w;
        if (cmd.mul)
        begin
            prod_reg     <= DIV_NUM_W'(mag * units_reg);
            smp_neg_reg  <= smp[11];
            smp_zero_reg <= smp == 12'd0;
        end
        if (cmd.finish)
        begin
            rd_reg  <= rd_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_x_reg   <= '0;
            count_y_reg   <= '0;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            sample_x_reg  <= '0;
            sample_y_reg  <= '0;
            latched_x_reg <= '0;
            latched_y_reg <= '0;
            button_reg    <= '0;
            rapid_reg     <= '0;
            last_time_reg <= '0;
            port_c_reg    <= PORT_C_RESET;
            mode_reg      <= MODE_RESET;
            shift_reg     <= '0;
            irq_due_reg   <= '0;
            armed_reg     <= 1'b0;
            irq_reg       <= 1'b0;
            irq_out_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                irq_reg <= 1'b0;
                if (armed_reg && due_now)
                begin
                    armed_reg <= 1'b0;
                    if (!port_c_reg[4])
                    begin
                        irq_reg     <= 1'b1;
                        irq_due_reg <= irq_due_reg + interval;
                        armed_reg   <= 1'b1;
                    end
                end
            end
            if (cmd.time_div)
                rapid_reg <= rapid_reg ^ RAPID_MASK;
            if (cmd.take_units)
                last_time_reg <= last_time_reg
                               + 32'({10'd0, units_w} * {16'd0, TICKS_PER_UNIT});
            if (cmd.apply)
            begin
                if (cmd.sel_y)
                begin
                    count_y_reg <= sat16(step_sum);
                    pend_y_reg  <= pend_y_reg - step[15:0];
                end
                else
                begin
                    count_x_reg <= sat16(step_sum);
                    pend_x_reg  <= pend_x_reg - step[15:0];
                end
            end
            if (cmd.finish)
            begin
                irq_out_reg <= irq_reg;
                if (write_en)
                begin
                    if (latch_edge)
                    begin
                        latched_x_reg <= clamp8(count_x_reg);
                        latched_y_reg <= clamp8(count_y_reg);
                        count_x_reg   <= '0;
                        count_y_reg   <= '0;
                    end
                    if (port_c_reg[4] && !wval[4] && !armed_reg)
                    begin
                        irq_due_reg <= now_reg + interval;
                        armed_reg   <= 1'b1;
                    end
                    port_c_reg <= wval;
                end
                case (kind_reg)
                    KIND_CONTROL:
                        if (data_reg[7])
                            mode_reg <= data_reg;
                    KIND_TIMING: shift_reg <= data_reg[1:0];
                    KIND_MOTION:
                    begin
                        count_x_reg   <= motion_x;
                        count_y_reg   <= motion_y;
                        sample_x_reg  <= mx_reg;
                        sample_y_reg  <= my_reg;
                        pend_x_reg    <= {{4{mx_reg[11]}}, mx_reg};
                        pend_y_reg    <= {{4{my_reg[11]}}, my_reg};
                        button_reg    <= btn_reg;
                        last_time_reg <= now_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign read_data = rd_reg;
    assign irq       = irq_out_reg;

endmodule

`default_nettype wire

@@ src/bus_mouse_ppi_interface_core.sv @@
// bus_mouse_ppi_interface_core: top level, register port, controller and datapath
// depends on bmp_pkg, bmp_req_if, bmp_rsp_if, bmp_ctrl, bmp_dp
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | req_type, data, move_x, move_y, buttons, now
//  rsp     | out | valid/ready   | read_data, irq
//  apb     | in  | psel/penable  | paddr[4:0], pwdata[31:0], prdata[31:0]
//
// one item at a time; when motion is spread, one reciprocal multiply for
// elapsed / 1000, then two passes of the divider by move_period
// a finished result sits in the output register; the next request is taken
// while it waits and stalls in its last step until the waiting result drains
// reset clears control, mouse, port and config state at once, not captured item or result data; no clearing pass
`default_nettype none

module bus_mouse_ppi_interface_core
    import bmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bmp_req_if.sink                 req,
    bmp_rsp_if.source               rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    status_t  status;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_period  <= MOVE_PERIOD_RESET;
            cfg_reg.irq_period   <= IRQ_PERIOD_RESET;
            cfg_reg.rapid_enable <= 1'b0;
            cfg_reg.dip_bank_a   <= '0;
            cfg_reg.dip_bank_c   <= '0;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (widx)
                REG_MOVE_PERIOD: cfg_reg.move_period  <= pwdata[15:0];
                REG_IRQ_PERIOD:  cfg_reg.irq_period   <= pwdata[23:0];
                REG_RAPID:       cfg_reg.rapid_enable <= pwdata[0];
                REG_DIP_A:       cfg_reg.dip_bank_a   <= pwdata[7:0];
                REG_DIP_C:       cfg_reg.dip_bank_c   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (widx)
                REG_MOVE_PERIOD: prdata = {16'h0, cfg_reg.move_period};
                REG_IRQ_PERIOD:  prdata = {8'h0, cfg_reg.irq_period};
                REG_RAPID:       prdata = {31'h0, cfg_reg.rapid_enable};
                REG_DIP_A:       prdata = {24'h0, cfg_reg.dip_bank_a};
                REG_DIP_C:       prdata = {24'h0, cfg_reg.dip_bank_c};
                default:         prdata = '0;
            endcase
        end
    end

    bmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .req_type  (req.req_type),
        .data      (req.data),
        .move_x    (req.move_x),
        .move_y    (req.move_y),
        .buttons   (req.buttons),
        .now       (req.now),
        .read_data (rsp.read_data),
        .irq       (rsp.irq)
    );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for bus_mouse_ppi_interface_core, request/result streams plus apb
// depends on bmp_pkg, bmp_req_if, bmp_rsp_if and the core under src
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmp_pkg::kind_t;
    import bmp_pkg::reg_idx_t;
    import bmp_pkg::KIND_WRITE_C;
    import bmp_pkg::KIND_CONTROL;
    import bmp_pkg::KIND_TIMING;
    import bmp_pkg::KIND_READ_A;
    import bmp_pkg::KIND_READ_B;
    import bmp_pkg::KIND_READ_C;
    import bmp_pkg::KIND_MOTION;
    import bmp_pkg::KIND_TICK;
    import bmp_pkg::REG_MOVE_PERIOD;
    import bmp_pkg::REG_IRQ_PERIOD;
    import bmp_pkg::REG_RAPID;
    import bmp_pkg::REG_DIP_A;
    import bmp_pkg::REG_DIP_C;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        logic [11:0] mx;
        logic [11:0] my;
        logic [7:0]  btn;
        logic [31:0] now;
        bit          typed;
        logic [7:0]  t_rd;
        logic        t_irq;
    } access_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
    } mouse_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [bmp_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmp_req_if req ();
    bmp_rsp_if rsp ();

    bus_mouse_ppi_interface_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the block state
    logic [15:0] m_move_period;
    logic [23:0] m_irq_period;
    logic        m_rapid_en;
    logic [7:0]  m_dip_a, m_dip_c;
    int          cnt_x, cnt_y, pend_x, pend_y, smp_x, smp_y, lat_x, lat_y;
    logic [7:0]  btn_byte, rapid_bits, port_c, mode_byte;
    logic [31:0] last_tick, irq_due;
    logic [1:0]  tshift;
    bit          irq_armed;

    mouse_result_t result_q[$];
    int  errors;
    int  idle_cycles;
    bit  hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int clip8(input int v);
        if (v > 127) return 127;
        if (v < -128) return -128;
        return v;
    endfunction

    function automatic logic [31:0] irq_step();
        logic [31:0] p;
        p = {8'd0, m_irq_period};
        return p << tshift;
    endfunction

    function automatic int spread_axis(input int smp, input int pend, input longint units);
        longint div, d;
        div = (m_move_period == 16'd0) ? 64'd1 : longint'(m_move_period);
        if (smp > 0)
        begin
            d = (longint'(smp) * units) / div;
            if (d > pend) d = pend;
        end
        else if (smp < 0)
        begin
            d = -((longint'(-smp) * units) / div);
            if (d < pend) d = pend;
        end
        else
            d = 0;
        return int'(d);
    endfunction

    function automatic void spread_motion(input logic [31:0] now);
        logic [31:0] diff;
        longint units;
        int d;
        diff = now - last_tick;
        if (diff[31] || diff < 32'd2000)
            return;
        rapid_bits ^= 8'ha0;
        units = longint'(diff / 32'd1000);
        d = spread_axis(smp_x, pend_x, units);
        cnt_x = clip16(cnt_x + d);
        pend_x = int'(shortint'(pend_x - d));
        d = spread_axis(smp_y, pend_y, units);
        cnt_y = clip16(cnt_y + d);
        pend_y = int'(shortint'(pend_y - d));
        last_tick += 32'(units * 1000);
    endfunction

    function automatic void port_c_write(input logic [7:0] value, input logic [31:0] now);
        if (value[7] && !port_c[7])
        begin
            spread_motion(now);
            lat_x = clip8(cnt_x);
            lat_y = clip8(cnt_y);
            cnt_x = 0;
            cnt_y = 0;
        end
        if ((value[4] != port_c[4]) && !value[4] && !irq_armed)
        begin
            irq_due = now + irq_step();
            irq_armed = 1'b1;
        end
        port_c = value;
    endfunction

    function automatic mouse_result_t predict_access(input access_t a);
        mouse_result_t r;
        logic [7:0]  bitm;
        logic [31:0] v;
        logic [31:0] due_gap;
        r.rd = 8'd0;
        r.irq = 1'b0;
        due_gap = a.now - irq_due;
        if (irq_armed && !due_gap[31])
        begin
            irq_armed = 1'b0;
            if (!port_c[4])
            begin
                r.irq = 1'b1;
                irq_due += irq_step();
                irq_armed = 1'b1;
            end
        end
        case (a.kind)
            KIND_WRITE_C: port_c_write(a.data, a.now);
            KIND_CONTROL:
            begin
                if (a.data[7:4] == 4'd0)
                begin
                    bitm = 8'd1 << a.data[3:1];
                    port_c_write(a.data[0] ? (port_c | bitm) : (port_c & ~bitm), a.now);
                end
                else if (a.data[7])
                begin
                    mode_byte = a.data;
                    port_c_write(8'd0, a.now);
                end
            end
            KIND_TIMING: tshift = a.data[1:0];
            KIND_READ_A:
            begin
                spread_motion(a.now);
                r.rd = btn_byte;
                if (m_rapid_en) r.rd |= rapid_bits;
                r.rd = (r.rd & 8'hf0) | 8'h50;
                if (port_c[7])
                    v = port_c[6] ? lat_y : lat_x;
                else
                    v = port_c[6] ? cnt_y : cnt_x;
                r.rd[3:0] = port_c[5] ? v[7:4] : v[3:0];
            end
            KIND_READ_B: r.rd = 8'h40;
            KIND_READ_C:
            begin
                r.rd = port_c;
                if (mode_byte[3]) r.rd &= 8'h1f;
                if (mode_byte[0])
                begin
                    r.rd = (r.rd & 8'hf0) | 8'h08;
                    r.rd[2] = m_dip_c[7];
                    r.rd[1:0] = ~m_dip_a[5:4];
                end
            end
            KIND_MOTION:
            begin
                cnt_x = clip16(cnt_x + pend_x);
                cnt_y = clip16(cnt_y + pend_y);
                smp_x = int'($signed(a.mx));
                smp_y = int'($signed(a.my));
                pend_x = smp_x;
                pend_y = smp_y;
                btn_byte = a.btn;
                last_tick = a.now;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic access_t mk(input kind_t k, input logic [7:0] d, input logic [11:0] x,
                                   input logic [11:0] y, input logic [7:0] b,
                                   input logic [31:0] now, input bit typed = 0,
                                   input logic [7:0] trd = 0, input logic tirq = 0);
        access_t a;
        a.kind = k; a.data = d; a.mx = x; a.my = y; a.btn = b; a.now = now;
        a.typed = typed; a.t_rd = trd; a.t_irq = tirq;
        return a;
    endfunction

    function automatic logic [11:0] rand_motion();
        case ($urandom_range(0, 3))
            0: return 12'($urandom);
            1: return 12'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 12'h7ff : 12'h800;
            default: return 12'h000;
        endcase
    endfunction

    function automatic access_t rand_access(inout logic [31:0] now);
        access_t a;
        int pick;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: now += $urandom_range(1000, 20000);
            6: now += $urandom_range(0, 1999);
            7: now -= $urandom_range(1, 3000);
            default: now += $urandom_range(20000, 600000);
        endcase
        a = mk(KIND_TICK, 8'($urandom), 12'($urandom), 12'($urandom), 8'($urandom), now);
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            a.kind = KIND_MOTION;
            a.mx = rand_motion();
            a.my = rand_motion();
        end
        else if (pick < 45) a.kind = KIND_READ_A;
        else if (pick < 60)
        begin
            a.kind = KIND_CONTROL;
            case ($urandom_range(0, 5))
                0: a.data = 8'h80 | 8'($urandom);
                1: a.data = 8'($urandom_range(16, 127));
                default: a.data = 8'($urandom_range(0, 15));
            endcase
        end
        else if (pick < 70) a.kind = KIND_WRITE_C;
        else if (pick < 78) a.kind = KIND_READ_C;
        else if (pick < 82) a.kind = KIND_READ_B;
        else if (pick < 87) a.kind = KIND_TIMING;
        return a;
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bmp_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MOVE_PERIOD: m_move_period = value[15:0];
            REG_IRQ_PERIOD:  m_irq_period = value[23:0];
            REG_RAPID:       m_rapid_en = value[0];
            REG_DIP_A:       m_dip_a = value[7:0];
            REG_DIP_C:       m_dip_c = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] mp, input logic [23:0] ip,
                                 input logic re, input logic [7:0] da, input logic [7:0] dc);
        apb_write(REG_MOVE_PERIOD, {16'd0, mp});
        apb_write(REG_IRQ_PERIOD, {8'd0, ip});
        apb_write(REG_RAPID, {31'd0, re});
        apb_write(REG_DIP_A, {24'd0, da});
        apb_write(REG_DIP_C, {24'd0, dc});
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one access, held until transfer; burst/gap shaping is left to the caller
    task automatic issue_access(input access_t a);
        mouse_result_t r;
        bit rdy;
        req.valid    <= 1'b1;
        req.req_type <= a.kind;
        req.data     <= a.data;
        req.move_x   <= a.mx;
        req.move_y   <= a.my;
        req.buttons  <= a.btn;
        req.now      <= a.now;
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end while (!rdy);
        r = predict_access(a);
        if (a.typed)
        begin
            r.rd = a.t_rd;
            r.irq = a.t_irq;
        end
        result_q.push_back(r);
    endtask

    int burst_left;

    task automatic paced_access(input access_t a);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        issue_access(a);
    endtask

    // stimulus
    initial
    begin
        access_t dir_tab[$];
        logic [31:0] now;
        int p;

        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req.valid = 1'b0; req.req_type = KIND_TICK; req.data = '0; req.move_x = '0;
        req.move_y = '0; req.buttons = '0; req.now = '0;
        errors = 0;
        hold_request = 0;
        burst_left = 0;
        m_move_period = 16'd354; m_irq_period = 24'd166400; m_rapid_en = 0;
        m_dip_a = 0; m_dip_c = 0;
        cnt_x = 0; cnt_y = 0; pend_x = 0; pend_y = 0; smp_x = 0; smp_y = 0;
        lat_x = 0; lat_y = 0; btn_byte = 0; rapid_bits = 0; last_tick = 0;
        port_c = 8'h10; mode_byte = 8'h93; tshift = 0; irq_due = 0; irq_armed = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, extremes, latch, bit set, mode load, time going back
        dir_tab.push_back(mk(KIND_READ_B, 8'h00, 0, 0, 0, 32'd0, 1, 8'h40, 0));
        dir_tab.push_back(mk(KIND_READ_C, 8'h00, 0, 0, 0, 32'd0, 1, 8'h1b, 0));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd0, 1, 8'h50, 0));
        dir_tab.push_back(mk(KIND_MOTION, 8'h00, 12'h7ff, 12'h800, 8'hff, 32'd100));
        dir_tab.push_back(mk(KIND_TICK, 8'hff, 0, 0, 0, 32'd5000));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd200000));
        dir_tab.push_back(mk(KIND_CONTROL, 8'h0f, 0, 0, 0, 32'd210000));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd211000));
        dir_tab.push_back(mk(KIND_CONTROL, 8'h0b, 0, 0, 0, 32'd212000));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd213000));
        dir_tab.push_back(mk(KIND_CONTROL, 8'h0d, 0, 0, 0, 32'd214000));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd215000));
        dir_tab.push_back(mk(KIND_WRITE_C, 8'h00, 0, 0, 0, 32'd216000));
        dir_tab.push_back(mk(KIND_TIMING, 8'hff, 0, 0, 0, 32'd217000));
        dir_tab.push_back(mk(KIND_CONTROL, 8'h9a, 0, 0, 0, 32'd218000));
        dir_tab.push_back(mk(KIND_CONTROL, 8'h50, 0, 0, 0, 32'd219000));
        dir_tab.push_back(mk(KIND_READ_C, 8'h00, 0, 0, 0, 32'd220000));
        dir_tab.push_back(mk(KIND_MOTION, 8'h00, 12'hfff, 12'h001, 8'h00, 32'd300000));
        dir_tab.push_back(mk(KIND_TICK, 8'h00, 0, 0, 0, 32'd299000));
        dir_tab.push_back(mk(KIND_READ_A, 8'h00, 0, 0, 0, 32'd400000));
        dir_tab.push_back(mk(KIND_WRITE_C, 8'h90, 0, 0, 0, 32'd401000));
        dir_tab.push_back(mk(KIND_MOTION, 8'h00, 12'h000, 12'h000, 8'h5a, 32'd402000));
        dir_tab.push_back(mk(KIND_READ_B, 8'h00, 0, 0, 0, 32'd403000, 1, 8'h40, 0));
        foreach (dir_tab[i])
            paced_access(dir_tab[i]);
        req.valid <= 1'b0;
        now = 32'd403000;

        for (p = 0; p < 6; p++)
        begin
            wait_drained();
            case (p)
                0: load_settings(16'd1, 24'd1, 1'b1, 8'hff, 8'hff);
                1: load_settings(16'hffff, 24'hffffff, 1'b0, 8'h00, 8'h00);
                2: load_settings(16'd0, 24'd3000, 1'b1, 8'($urandom), 8'($urandom));
                default: load_settings(16'($urandom_range(1, 2000)),
                                       24'($urandom_range(1000, 60000)), 1'($urandom),
                                       8'($urandom), 8'($urandom));
            endcase
            if (p == 3) now = 32'hfff0_0000;
            if (p == 4) now = $urandom;
            @(posedge clk);
            for (int n = 0; n < 92; n++)
            begin
                if (p == 2 && n == 20) hold_request = 1;
                paced_access(rand_access(now));
            end
            req.valid <= 1'b0;
        end

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side stall pattern, with one long hold-off on request
    initial
    begin
        int seg;
        bit stall_mode;
        rsp.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall_mode = $urandom_range(0, 1);
                seg = $urandom_range(10, 60);
                repeat (seg)
                begin
                    rsp.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    // result checking and watchdog
    initial
    begin
        bit r_take, q_take;
        mouse_result_t got, want;
        idle_cycles = 0;
        forever
        begin
            @(negedge clk);
            r_take = rsp.valid && rsp.ready;
            q_take = req.valid && req.ready;
            got.rd = rsp.read_data;
            got.irq = rsp.irq;
            @(posedge clk);
            if (r_take)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got rd=%h irq=%b",
                             $time, got.rd, got.irq);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.rd !== want.rd)
                    begin
                        $display("%0t: read_data mismatch expected %h actual %h",
                                 $time, want.rd, got.rd);
                        errors++;
                    end
                    if (got.irq !== want.irq)
                    begin
                        $display("%0t: irq mismatch expected %b actual %b",
                                 $time, want.irq, got.irq);
                        errors++;
                    end
                end
            end
            if (r_take || q_take || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
